@@ design/mkpc_pkg.sv @@
// Package for the multi-key press classifier: event and key codes, register
// indexes, register reset values and the hold counter advance function.
// Depends on nothing; the top level of the block imports it.
`default_nettype none

package mkpc_pkg;

    localparam int NUM_KEYS = 5;
    localparam int PRE_W    = 8;
    localparam int HOLD_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_HOLD  = 3'd1,
        EV_SHORT = 3'd2,
        EV_LONG  = 3'd3,
        EV_PAIR  = 3'd4,
        EV_ENTER = 3'd5,
        EV_EXIT  = 3'd6
    } event_kind_t;

    localparam logic [2:0] KEY_REAR_A  = 3'd0;
    localparam logic [2:0] KEY_REAR_B  = 3'd1;
    localparam logic [2:0] KEY_FRONT_A = 3'd2;
    localparam logic [2:0] KEY_FRONT_B = 3'd3;
    localparam logic [2:0] KEY_COMBO   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SATURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_EVENT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_DWELL     = 3'd5;

    localparam logic [PRE_W-1:0]  RST_PRESCALE_LIMIT  = 8'd100;
    localparam logic [HOLD_W-1:0] RST_HOLD_SATURATION = 12'd3000;
    localparam logic [HOLD_W-1:0] RST_HOLD_EVENT      = 12'd2000;
    localparam logic [HOLD_W-1:0] RST_LONG_LEVEL      = 12'd1500;
    localparam logic [HOLD_W-1:0] RST_SHORT_MIN       = 12'd50;
    localparam logic [PRE_W-1:0]  RST_COMBO_DWELL     = 8'd200;

    typedef struct packed {
        logic [PRE_W-1:0]  pre;
        logic [HOLD_W-1:0] hold;
        logic              bump;
    } adv_t;

    // One tick of a held key: the prescaler counts up to the limit, then
    // restarts and bumps the saturating hold counter.
    function automatic adv_t advance(input logic [PRE_W-1:0]  pre,
                                     input logic [HOLD_W-1:0] hold,
                                     input logic [PRE_W-1:0]  limit,
                                     input logic [HOLD_W-1:0] sat);
        adv_t r;
        begin
            if (pre < limit)
            begin
                r.pre  = pre + 8'd1;
                r.hold = hold;
                r.bump = 1'b0;
            end
            else
            begin
                r.pre  = '0;
                r.hold = (hold < sat) ? hold + 12'd1 : hold;
                r.bump = 1'b1;
            end
            return r;
        end
    endfunction

    function automatic logic in_short(input logic [HOLD_W-1:0] c,
                                      input logic [HOLD_W-1:0] smin,
                                      input logic [HOLD_W-1:0] lng);
        return (c > smin) && (c < lng);
    endfunction

endpackage

`default_nettype wire

@@ design/mkpc_if.sv @@
// Valid/ready channel interfaces for the key level beats and event beats.
// Depends on nothing but the handshake convention of the block.
`default_nettype none

interface mkpc_key_if;
    logic valid;
    logic ready;
    logic rear_a_level;
    logic rear_b_level;
    logic front_a_level;
    logic front_b_level;
    logic mode_key_level;

    modport source (output valid, rear_a_level, rear_b_level, front_a_level,
                    front_b_level, mode_key_level, input ready);
    modport sink   (input valid, rear_a_level, rear_b_level, front_a_level,
                    front_b_level, mode_key_level, output ready);
endinterface

interface mkpc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [2:0] event_key;

    modport source (output valid, event_kind, event_key, input ready);
    modport sink   (input valid, event_kind, event_key, output ready);
endinterface

`default_nettype wire

@@ design/multi_key_press_classifier_unit.sv @@
// Top level of the multi-key press classifier: counter state, register
// file, the per-tick classification and the output register.
// Depends on mkpc_pkg and the channel interfaces in mkpc_if.sv.
`default_nettype none

// Each input beat is one tick carrying five active-low key levels; each tick
// yields exactly one event beat (kind none when nothing happened). The whole
// tick is worked out combinationally from the stored counters and the
// incoming levels, and the result sits in a single output register; a new
// tick is taken in every cycle for as long as the event side keeps taking
// beats. The output register sets that rate: a tick is accepted whenever
// the register is empty or is being emptied in the same cycle. Registers
// are written through a plain write port and should only be changed while
// no tick is in flight.
module multi_key_press_classifier_unit
    import mkpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mkpc_key_if.sink                   key_in,
    mkpc_event_if.source               event_out,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [PRE_W-1:0]  prescale_limit_reg;
    logic [HOLD_W-1:0] hold_saturation_reg;
    logic [HOLD_W-1:0] hold_event_level_reg;
    logic [HOLD_W-1:0] long_level_reg;
    logic [HOLD_W-1:0] short_min_level_reg;
    logic [PRE_W-1:0]  combo_dwell_reg;

    // Per-key counters and the combination dwell counter.
    logic [PRE_W-1:0]  prescale_reg [NUM_KEYS];
    logic [HOLD_W-1:0] hold_reg     [NUM_KEYS];
    logic [PRE_W-1:0]  combo_count_reg;
    logic [PRE_W-1:0]  prescale_next [NUM_KEYS];
    logic [HOLD_W-1:0] hold_next     [NUM_KEYS];
    logic [PRE_W-1:0]  combo_count_next;

    // Output register.
    logic              out_valid_reg;
    event_kind_t       kind_reg;
    logic [2:0]        key_reg;
    event_kind_t       kind_next;
    logic [2:0]        key_next;

    logic              accept;
    logic [NUM_KEYS-1:0] down;

    assign key_in.ready = !out_valid_reg || event_out.ready;
    assign accept       = key_in.valid && key_in.ready;

    assign event_out.valid      = out_valid_reg;
    assign event_out.event_kind = kind_reg;
    assign event_out.event_key  = key_reg;

    // Pin level low means the key is held.
    assign down = {!key_in.mode_key_level, !key_in.front_b_level,
                   !key_in.front_a_level, !key_in.rear_b_level,
                   !key_in.rear_a_level};

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_limit_reg   <= RST_PRESCALE_LIMIT;
            hold_saturation_reg  <= RST_HOLD_SATURATION;
            hold_event_level_reg <= RST_HOLD_EVENT;
            long_level_reg       <= RST_LONG_LEVEL;
            short_min_level_reg  <= RST_SHORT_MIN;
            combo_dwell_reg      <= RST_COMBO_DWELL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRESCALE_LIMIT:  prescale_limit_reg   <= cfg_wdata[PRE_W-1:0];
                CFG_HOLD_SATURATION: hold_saturation_reg  <= cfg_wdata[HOLD_W-1:0];
                CFG_HOLD_EVENT:      hold_event_level_reg <= cfg_wdata[HOLD_W-1:0];
                CFG_LONG_LEVEL:      long_level_reg       <= cfg_wdata[HOLD_W-1:0];
                CFG_SHORT_MIN:       short_min_level_reg  <= cfg_wdata[HOLD_W-1:0];
                CFG_COMBO_DWELL:     combo_dwell_reg      <= cfg_wdata[PRE_W-1:0];
                default: ;
            endcase
        end
    end

    // One tick. The keys are visited in the order rear a, rear b, front a,
    // front b, mode key, then the combination; the first event found stops
    // the walk, so the keys after it keep their counters for this tick. Each
    // stage sees the counters as left by the stages before it.
    always_comb
    begin
        adv_t a;
        logic done;

        a         = '0;
        done      = 1'b0;
        kind_next = EV_NONE;
        key_next  = KEY_REAR_A;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            prescale_next[k] = prescale_reg[k];
            hold_next[k]     = hold_reg[k];
        end
        combo_count_next = combo_count_reg;

        // Rear a: a hold event only while rear b is already long and no
        // combination is running; a short release is silent.
        if (down[0])
        begin
            a = advance(prescale_next[0], hold_next[0], prescale_limit_reg,
                        hold_saturation_reg);
            prescale_next[0] = a.pre;
            hold_next[0]     = a.hold;
            if (a.bump && hold_next[0] == hold_event_level_reg &&
                hold_next[1] > long_level_reg && combo_count_reg == '0)
            begin
                kind_next = EV_HOLD;
                key_next  = KEY_REAR_A;
                done      = 1'b1;
            end
        end
        else if (!in_short(hold_next[0], short_min_level_reg, long_level_reg) &&
                 hold_next[0] > long_level_reg)
        begin
            hold_next[0] = '0;
            kind_next    = EV_LONG;
            key_next     = KEY_REAR_A;
            done         = 1'b1;
        end
        else
        begin
            prescale_next[0] = '0;
            hold_next[0]     = '0;
        end

        // Rear b: its releases are classified only outside a combination;
        // both rear keys in the short window make a pair short.
        if (!done)
        begin
            if (down[1])
            begin
                a = advance(prescale_next[1], hold_next[1], prescale_limit_reg,
                            hold_saturation_reg);
                prescale_next[1] = a.pre;
                hold_next[1]     = a.hold;
                if (a.bump && hold_next[1] == hold_event_level_reg &&
                    hold_next[0] == '0 && combo_count_reg == '0)
                begin
                    kind_next = EV_HOLD;
                    key_next  = KEY_REAR_B;
                    done      = 1'b1;
                end
            end
            else
            begin
                if (combo_count_reg == '0)
                begin
                    if (in_short(hold_next[0], short_min_level_reg, long_level_reg) &&
                        in_short(hold_next[1], short_min_level_reg, long_level_reg))
                    begin
                        hold_next[0] = '0;
                        hold_next[1] = '0;
                        kind_next    = EV_PAIR;
                        key_next     = KEY_COMBO;
                        done         = 1'b1;
                    end
                    else if (in_short(hold_next[1], short_min_level_reg,
                                      long_level_reg))
                    begin
                        hold_next[1] = '0;
                        kind_next    = EV_SHORT;
                        key_next     = KEY_REAR_B;
                        done         = 1'b1;
                    end
                    else if (hold_next[1] > hold_event_level_reg)
                    begin
                        hold_next[1] = '0;
                        kind_next    = EV_LONG;
                        key_next     = KEY_REAR_B;
                        done         = 1'b1;
                    end
                end
                if (!done)
                begin
                    prescale_next[1] = '0;
                    hold_next[1]     = '0;
                end
            end
        end

        // Front a.
        if (!done)
        begin
            if (down[2])
            begin
                a = advance(prescale_next[2], hold_next[2], prescale_limit_reg,
                            hold_saturation_reg);
                prescale_next[2] = a.pre;
                hold_next[2]     = a.hold;
                if (a.bump && hold_next[2] == hold_event_level_reg)
                begin
                    kind_next = EV_HOLD;
                    key_next  = KEY_FRONT_A;
                    done      = 1'b1;
                end
            end
            else
            begin
                if (combo_count_reg == '0)
                begin
                    if (in_short(hold_next[2], short_min_level_reg, long_level_reg))
                    begin
                        hold_next[2] = '0;
                        kind_next    = EV_SHORT;
                        key_next     = KEY_FRONT_A;
                        done         = 1'b1;
                    end
                    else if (hold_next[2] > long_level_reg)
                    begin
                        hold_next[2] = '0;
                        kind_next    = EV_LONG;
                        key_next     = KEY_FRONT_A;
                        done         = 1'b1;
                    end
                end
                if (!done)
                begin
                    prescale_next[2] = '0;
                    hold_next[2]     = '0;
                end
            end
        end

        // Front b: releases are never reported.
        if (!done)
        begin
            if (down[3])
            begin
                a = advance(prescale_next[3], hold_next[3], prescale_limit_reg,
                            hold_saturation_reg);
                prescale_next[3] = a.pre;
                hold_next[3]     = a.hold;
                if (a.bump && hold_next[3] == hold_event_level_reg)
                begin
                    kind_next = EV_HOLD;
                    key_next  = KEY_FRONT_B;
                    done      = 1'b1;
                end
            end
            else
            begin
                prescale_next[3] = '0;
                hold_next[3]     = '0;
            end
        end

        // Mode key: a long hold enters the mode, its release exits it.
        if (!done)
        begin
            if (down[4])
            begin
                a = advance(prescale_next[4], hold_next[4], prescale_limit_reg,
                            hold_saturation_reg);
                prescale_next[4] = a.pre;
                hold_next[4]     = a.hold;
                if (a.bump && hold_next[4] == hold_event_level_reg)
                begin
                    kind_next = EV_ENTER;
                    key_next  = KEY_COMBO;
                    done      = 1'b1;
                end
            end
            else
            begin
                if (hold_next[4] > hold_event_level_reg)
                begin
                    kind_next = EV_EXIT;
                    key_next  = KEY_COMBO;
                    done      = 1'b1;
                end
                prescale_next[4] = '0;
                hold_next[4]     = '0;
            end
        end

        // Combination of front a and rear b both held long.
        if (!done)
        begin
            if (hold_next[2] > long_level_reg && hold_next[1] > long_level_reg)
            begin
                if (combo_count_reg < combo_dwell_reg)
                begin
                    combo_count_next = combo_count_reg + 8'd1;
                end
                else
                begin
                    kind_next = EV_ENTER;
                    key_next  = KEY_COMBO;
                end
            end
            else if (combo_count_reg != '0 && combo_count_reg >= combo_dwell_reg)
            begin
                combo_count_next = '0;
                kind_next        = EV_EXIT;
                key_next         = KEY_COMBO;
            end
        end
    end

    // Counter state advances only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                prescale_reg[k] <= '0;
                hold_reg[k]     <= '0;
            end
            combo_count_reg <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                prescale_reg[k] <= prescale_next[k];
                hold_reg[k]     <= hold_next[k];
            end
            combo_count_reg <= combo_count_next;
        end
    end

    // Output register: filled by an accepted tick, emptied when the beat is
    // taken and no new tick replaces it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (event_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_next;
            key_reg  <= key_next;
        end
    end

    // An accepted tick always leaves an event beat waiting in the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick left no event beat");

    // Pair, enter and exit events always name the combination key.
    a_combo_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == EV_PAIR || kind_reg == EV_ENTER ||
                           kind_reg == EV_EXIT)) |-> key_reg == KEY_COMBO)
        else $error("combination event with a single key index");

    // A tick without an event reports key zero.
    a_none_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == EV_NONE) |-> key_reg == KEY_REAR_A)
        else $error("empty event carries a key index");

    // The dwell counter only moves on an accepted tick.
    a_combo_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(combo_count_reg))
        else $error("dwell counter changed without a tick");

endmodule

`default_nettype wire
